### rtl/core/ntc_pkg.sv
`default_nettype none
package ntc_pkg;
  localparam logic [1:0] TypeF32 = 2'd0;
  localparam logic [1:0] TypeI32 = 2'd1;
  localparam logic [1:0] TypeI64 = 2'd2;

  localparam logic [1:0] RegSource = 2'd0;
  localparam logic [1:0] RegDest   = 2'd1;

  typedef enum logic [2:0] {
    OpZero, OpPass, OpF2I32, OpF2I64, OpI2F
  } op_e;

  // stage 1 -> stage 2
  typedef struct packed {
    op_e         op;
    logic        sgn;
    logic [63:0] mag;      // int magnitude, float significand or passthrough bits
    logic        err;
    logic        zero;
    logic [5:0]  sh;       // float->int shift amount
    logic        left;     // float->int shift direction
  } s1_t;

  // stage 2 -> stage 3
  typedef struct packed {
    op_e         op;
    logic        sgn;
    logic [63:0] mag;      // normalized magnitude or shifted integer
    logic [6:0]  p;        // leading one position
    logic        err;
    logic        zero;
  } s2_t;
endpackage
`default_nettype wire

### rtl/core/ntc_decode.sv
`default_nettype none
module ntc_decode (
  input  wire logic [1:0]  src_i,
  input  wire logic [1:0]  dst_i,
  input  wire logic [63:0] value_i,
  output ntc_pkg::s1_t     s1_o
);
  logic [31:0] f;
  logic [7:0]  ex;
  logic [63:0] v;
  logic [7:0]  e;
  logic [5:0]  lim;
  always_comb begin
    f   = value_i[31:0];
    ex  = f[30:23];
    v   = (src_i == ntc_pkg::TypeI32) ? {{32{f[31]}}, f} : value_i;
    s1_o = '0;
    s1_o.op = ntc_pkg::OpZero;
    e   = ex - 8'd127;
    lim = (dst_i == ntc_pkg::TypeI32) ? 6'd31 : 6'd63;
    if (src_i == ntc_pkg::TypeF32) begin
      if (dst_i == ntc_pkg::TypeF32) begin
        s1_o.op  = ntc_pkg::OpPass;
        s1_o.mag = {32'd0, f};
      end else if (dst_i == ntc_pkg::TypeI32 || dst_i == ntc_pkg::TypeI64) begin
        s1_o.op  = (dst_i == ntc_pkg::TypeI32) ? ntc_pkg::OpF2I32 : ntc_pkg::OpF2I64;
        s1_o.sgn = f[31];
        s1_o.mag = {40'd0, 1'b1, f[22:0]};
        if (ex == 8'hFF) s1_o.err = 1'b1;
        else if (ex < 8'd127) s1_o.zero = 1'b1;
        else if (e > {2'b0, lim} ||
                 (e == {2'b0, lim} && !(f[31] && f[22:0] == 23'd0)))
          s1_o.err = 1'b1;
        s1_o.left = (e >= 8'd23);
        s1_o.sh   = (e >= 8'd23) ? 6'(e - 8'd23) : 6'(8'd23 - e);
      end
    end else if (src_i == ntc_pkg::TypeI32 || src_i == ntc_pkg::TypeI64) begin
      if (dst_i == ntc_pkg::TypeF32) begin
        s1_o.op  = ntc_pkg::OpI2F;
        s1_o.sgn = v[63];
        s1_o.mag = v[63] ? (64'd0 - v) : v;
      end else if (dst_i == ntc_pkg::TypeI32) begin
        s1_o.op  = ntc_pkg::OpPass;
        s1_o.mag = {32'd0, v[31:0]};
      end else if (dst_i == ntc_pkg::TypeI64) begin
        s1_o.op  = ntc_pkg::OpPass;
        s1_o.mag = v;
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/ntc_shift.sv
`default_nettype none
module ntc_shift (
  input  wire ntc_pkg::s1_t s1_i,
  output ntc_pkg::s2_t      s2_o
);
  logic [6:0] p;
  always_comb begin
    p = 7'd0;
    for (int i = 0; i < 64; i++)
      if (s1_i.mag[i]) p = 7'(i);
    s2_o.op   = s1_i.op;
    s2_o.sgn  = s1_i.sgn;
    s2_o.err  = s1_i.err;
    s2_o.zero = s1_i.zero || (s1_i.mag == 64'd0);
    s2_o.p    = p;
    if (s1_i.op == ntc_pkg::OpI2F)
      s2_o.mag = s1_i.mag << (7'd63 - p);
    else if (s1_i.op == ntc_pkg::OpF2I32 || s1_i.op == ntc_pkg::OpF2I64)
      s2_o.mag = s1_i.left ? (s1_i.mag << s1_i.sh) : (s1_i.mag >> s1_i.sh);
    else
      s2_o.mag = s1_i.mag;
  end
endmodule
`default_nettype wire

### rtl/core/ntc_finish.sv
`default_nettype none
module ntc_finish (
  input  wire ntc_pkg::s2_t s2_i,
  output logic [63:0]       result_o,
  output logic              err_o
);
  logic [24:0] sig;
  logic        rnd;
  logic [7:0]  ex;
  logic [63:0] neg;
  always_comb begin
    // mag normalized with leading one at bit 63; keep 24 bits
    rnd = s2_i.mag[39] && (s2_i.mag[38:0] != 39'd0 || s2_i.mag[40]);
    sig = {1'b0, s2_i.mag[63:40]} + {24'd0, rnd};
    ex  = 8'(s2_i.p) + 8'd127 + {7'd0, sig[24]};
    neg = s2_i.sgn ? (64'd0 - s2_i.mag) : s2_i.mag;
    result_o = 64'd0;
    err_o    = 1'b0;
    case (s2_i.op)
      ntc_pkg::OpPass: result_o = s2_i.mag;
      ntc_pkg::OpI2F: begin
        if (!s2_i.zero)
          result_o = {32'd0, s2_i.sgn, ex, sig[24] ? sig[23:1] : sig[22:0]};
      end
      ntc_pkg::OpF2I32: begin
        err_o = s2_i.err;
        if (!s2_i.err && !s2_i.zero) result_o = {32'd0, neg[31:0]};
      end
      ntc_pkg::OpF2I64: begin
        err_o = s2_i.err;
        if (!s2_i.err && !s2_i.zero) result_o = neg;
      end
      default: result_o = 64'd0;
    endcase
  end
endmodule
`default_nettype wire

### rtl/core/numeric_type_converter.sv
`default_nettype none
// Converts 64-bit words between float32, int32 and int64 as set by the source
// and dest type registers (index 0 and 1). Float to int truncates, int to float
// rounds to nearest even, non-finite or out-of-range floats give 0 with the
// error bit. Registered decode, shift and round/negate stages pass one word per
// cycle unless the output stalls. Write config only while the pipe is empty.
module numeric_type_converter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [1:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // value_bits
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [63:0]      m_axis_tdata_o,   // result_bits
  output logic             m_axis_tuser_o    // range_error
);
  logic [1:0] src_q, dst_q;
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  ntc_pkg::s1_t s1_d, s1_q;
  ntc_pkg::s2_t s2_d, s2_q;
  logic [63:0] r_d, r_q;
  logic e_d, e_q;

  assign cfg_ready_o = 1'b1;
  assign en3 = !v3_q || m_axis_tready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= ntc_pkg::TypeF32;
      dst_q <= ntc_pkg::TypeF32;
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_index_i == ntc_pkg::RegSource) src_q <= cfg_data_i;
      if (cfg_valid_i && cfg_index_i == ntc_pkg::RegDest) dst_q <= cfg_data_i;
      if (en1) v1_q <= s_axis_tvalid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
    if (en2) s2_q <= s2_d;
    if (en3) begin
      r_q <= r_d;
      e_q <= e_d;
    end
  end

  ntc_decode u_dec (.src_i(src_q), .dst_i(dst_q), .value_i(s_axis_tdata_i), .s1_o(s1_d));
  ntc_shift  u_sh  (.s1_i(s1_q), .s2_o(s2_d));
  ntc_finish u_fin (.s2_i(s2_q), .result_o(r_d), .err_o(e_d));

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = r_q;
  assign m_axis_tuser_o  = e_q;
endmodule
`default_nettype wire
